// File: rtl/door_lock_alarm_bell_controller_macros.svh
// ----------------------------------------------------------------------------
// Door lock controller assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DOOR_LOCK_ALARM_BELL_CONTROLLER_MACROS_SVH
`define DOOR_LOCK_ALARM_BELL_CONTROLLER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define DLAB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define DLAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dlab_pkg.sv
// ----------------------------------------------------------------------------
// Door lock controller package
// Register indexes, tone codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlab_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ToneW   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOGGLE_HOLDOFF = 2'd0,
    CFG_ALARM_HALF     = 2'd1,
    CFG_BELL_FIRST     = 2'd2,
    CFG_BELL_TOTAL     = 2'd3
  } cfg_idx_e;

  typedef enum logic [ToneW-1:0] {
    TONE_SILENT     = 3'd0,
    TONE_BELL_HIGH  = 3'd1,
    TONE_BELL_LOW   = 3'd2,
    TONE_ALARM_HIGH = 3'd3,
    TONE_ALARM_LOW  = 3'd4
  } tone_e;

  localparam logic [CfgW-1:0] RstToggleHoldoff = 16'd250;
  localparam logic [CfgW-1:0] RstAlarmHalf     = 16'd300;
  localparam logic [CfgW-1:0] RstBellFirst     = 16'd500;
  localparam logic [CfgW-1:0] RstBellTotal     = 16'd1000;

  // Input item fields
  typedef struct packed {
    logic remote_lock;
    logic remote_valid;
    logic bell_pressed;
    logic door_is_closed;
    logic toggle_pressed;
  } in_item_t;

  // Result item fields
  typedef struct packed {
    logic            door_closed_flag;
    logic            alarm_on;
    logic [ToneW-1:0] tone_code;
    logic            led_green;
    logic            led_red;
    logic            servo_locked;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/door_lock_alarm_bell_controller.sv
// Path: an accepted transaction is captured in the input register, then its result in the
//   result register, held from then on in m_axis_tdata until taken.
// Throughput: one transaction per cycle while the result side keeps tready high.
// Reset (rst_ni low, asynchronous): lock open, green LED on, tone silent,
//   counters cleared, configuration back to 250/300/500/1000 ms.
// ----------------------------------------------------------------------------
// Door lock, alarm and doorbell controller
// Per-tick lock, alarm and bell sequencing with servo, LED and tone outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "door_lock_alarm_bell_controller_macros.svh"

module door_lock_alarm_bell_controller
  import dlab_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  // tick input stream
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // [0] toggle_pressed, [1] door_is_closed, [2] bell_pressed,
  // [3] remote_valid, [4] remote_lock, [7:5] zero
  input  wire logic [7:0]          s_axis_tdata,
  // result stream
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] servo_locked, [1] led_red, [2] led_green, [5:3] tone_code,
  // [6] alarm_on, [7] door_closed_flag
  output      logic [7:0]          m_axis_tdata
);

  // Compare width wide enough for both a counter and a 16-bit register.
  localparam int unsigned CmpW = (COUNTER_BITS > CfgW) ? COUNTER_BITS : CfgW;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] holdoff_q, half_q, first_q, total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q <= RstToggleHoldoff;
      half_q    <= RstAlarmHalf;
      first_q   <= RstBellFirst;
      total_q   <= RstBellTotal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TOGGLE_HOLDOFF: holdoff_q <= cfg_data_i;
        CFG_ALARM_HALF:     half_q    <= cfg_data_i;
        CFG_BELL_FIRST:     first_q   <= cfg_data_i;
        CFG_BELL_TOTAL:     total_q   <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register feeds result register; both advance together
  // unless the result side stalls.
  // --------------------------------------------------------------------------
  logic     in_v_q, out_v_q;
  in_item_t in_q;
  logic     out_adv, in_adv, s_fire;

  assign out_adv       = !out_v_q || m_axis_tready;
  assign in_adv        = in_v_q && out_adv;          // item moves into result reg
  assign s_axis_tready = !in_v_q || out_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Controller state; the door flag is rewritten every tick and lives in the
  // result register only.
  // --------------------------------------------------------------------------
  logic            lock_q, alarm_q, phase_q, bell_run_q, red_q, green_q;
  cnt_t            since_tog_q, since_flip_q, bell_el_q;
  logic [ToneW-1:0] tone_q;

  logic            lock_d, door_d, alarm_d, phase_d, bell_run_d, red_d, green_d;
  cnt_t            since_tog_d, since_flip_d, bell_el_d;
  logic [ToneW-1:0] tone_d;

  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c == '1) ? c : c + cnt_t'(1);
  endfunction

  function automatic logic [CmpW-1:0] ext_cnt(input cnt_t c);
    ext_cnt = CmpW'(c);
  endfunction

  function automatic logic [CmpW-1:0] ext_cfg(input logic [CfgW-1:0] c);
    ext_cfg = CmpW'(c);
  endfunction

  // One tick of work, in the fixed order: remote, door, toggle or alarm, bell, tone.
  always_comb begin
    since_tog_d  = sat_inc(since_tog_q);
    since_flip_d = sat_inc(since_flip_q);
    bell_el_d    = sat_inc(bell_el_q);
    lock_d       = lock_q;
    alarm_d      = alarm_q;
    phase_d      = phase_q;
    bell_run_d   = bell_run_q;
    red_d        = red_q;
    green_d      = green_q;
    tone_d       = tone_q;

    // Apply a remote command that changes the lock.
    if (in_q.remote_valid && (in_q.remote_lock != lock_q)) begin
      lock_d  = in_q.remote_lock;
      red_d   = alarm_q || in_q.remote_lock;
      green_d = !(alarm_q || in_q.remote_lock);
    end

    door_d = in_q.door_is_closed;

    // Held button repeats the toggle after the holdoff; released, evaluate alarm.
    if (in_q.toggle_pressed) begin
      if (ext_cnt(since_tog_d) > ext_cfg(holdoff_q)) begin
        lock_d      = !lock_d;
        since_tog_d = '0;
        red_d       = alarm_q || lock_d;
        green_d     = !(alarm_q || lock_d);
      end
    end else begin
      alarm_d = lock_d && !door_d;
    end

    // Start an idle bell; unless the alarm is on, the first tone sounds this same tick.
    if (in_q.bell_pressed && !bell_run_q) begin
      bell_run_d = 1'b1;
      bell_el_d  = '0;
    end

    if (alarm_d) begin
      if (ext_cnt(since_flip_d) > ext_cfg(half_q)) begin
        since_flip_d = '0;
        phase_d      = !phase_q;
        tone_d       = phase_d ? TONE_ALARM_HIGH : TONE_ALARM_LOW;
        red_d        = phase_d;
        green_d      = 1'b0;
      end
    end else if (bell_run_d) begin
      if (ext_cnt(bell_el_d) < ext_cfg(first_q)) begin
        tone_d = TONE_BELL_HIGH;
      end else if (ext_cnt(bell_el_d) < ext_cfg(total_q)) begin
        tone_d = TONE_BELL_LOW;
      end else begin
        bell_run_d = 1'b0;
        tone_d     = TONE_SILENT;
        red_d      = lock_d;
        green_d    = !lock_d;
      end
    end else begin
      tone_d = TONE_SILENT;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      lock_q       <= 1'b0;
      alarm_q      <= 1'b0;
      phase_q      <= 1'b0;
      bell_run_q   <= 1'b0;
      red_q        <= 1'b0;
      green_q      <= 1'b1;
      tone_q       <= TONE_SILENT;
      since_tog_q  <= '0;
      since_flip_q <= '0;
      bell_el_q    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_v_q <= in_v_q;
      end
      // Commit the state only when the item lands in the result register.
      if (in_adv) begin
        lock_q       <= lock_d;
        alarm_q      <= alarm_d;
        phase_q      <= phase_d;
        bell_run_q   <= bell_run_d;
        red_q        <= red_d;
        green_q      <= green_d;
        tone_q       <= tone_d;
        since_tog_q  <= since_tog_d;
        since_flip_q <= since_flip_d;
        bell_el_q    <= bell_el_d;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q <= in_item_t'(s_axis_tdata[4:0]);
    end
    if (in_adv) begin
      out_q.servo_locked     <= lock_d;
      out_q.led_red          <= red_d;
      out_q.led_green        <= green_d;
      out_q.tone_code        <= tone_d;
      out_q.alarm_on         <= alarm_d;
      out_q.door_closed_flag <= door_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DLAB_ASSERT_SAME(a_leds_exclusive, clk_i, rst_ni, 1'b1, !(red_q && green_q),
    "red and green LEDs both on")
  `DLAB_ASSERT_SAME(a_bell_tone_running, clk_i, rst_ni,
    (tone_q == TONE_BELL_HIGH) || (tone_q == TONE_BELL_LOW), bell_run_q,
    "bell tone without a running bell")
  `DLAB_ASSERT_SAME(a_alarm_tone_alarm, clk_i, rst_ni,
    (tone_q == TONE_ALARM_HIGH) || (tone_q == TONE_ALARM_LOW), alarm_q,
    "alarm tone without alarm flag")
  `DLAB_ASSERT_NEXT(a_stall_holds_input, clk_i, rst_ni,
    in_v_q && out_v_q && !m_axis_tready, in_v_q && $stable(in_q),
    "pending input item lost during output stall")

endmodule

`default_nettype wire
